@@ sv/ptp_pkg.sv @@
// ---------------------------------------------------------------------------
// ptp_pkg: shared types and constants for the periodic timer pool
// Item formats, request and status codes, and controller/datapath interface.
// ---------------------------------------------------------------------------
package ptp_pkg;

   localparam int TIMERS = 8;
   localparam int SLOT_W = (TIMERS > 1) ? $clog2(TIMERS) : 1;
   localparam int CNT_W  = $clog2(TIMERS + 1);

   localparam logic [2:0] REQ_TICK   = 3'd0;
   localparam logic [2:0] REQ_CREATE = 3'd1;
   localparam logic [2:0] REQ_START  = 3'd2;
   localparam logic [2:0] REQ_STOP   = 3'd3;
   localparam logic [2:0] REQ_QUERY  = 3'd4;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_FULL    = 2'd1;
   localparam logic [1:0] ST_REFUSED = 2'd2;

   localparam logic KIND_ACK   = 1'b0;
   localparam logic KIND_FIRED = 1'b1;

   typedef struct packed {
      logic [2:0]  req_type;
      logic [2:0]  timer_id;
      logic        has_handler;
      logic [15:0] multiplier;
      logic [15:0] count;
   } req_item_type;

   typedef struct packed {
      logic       result_kind;
      logic [2:0] timer_id_res;
      logic [1:0] status;
      logic       active;
      logic       last;
   } rsp_item_type;

   typedef struct packed {
      logic capture;
      logic exec_req;
      logic walk_start;
      logic walk_step;
      logic flush;
   } ctrl_cmd_type;

   typedef struct packed {
      logic is_tick;
      logic walk_last;
      logic walk_blocked;
      logic pending;
      logic out_free;
   } dp_status_type;

endpackage

@@ sv/periodic_timer_pool.sv @@
// A request other than a tick is captured, then executed once the result register is free;
// its acknowledgement is registered. A tick walks all 8 slots, one per cycle while no held
// fired slot is blocked; its final fired item is sent in the flush step after the walk.
// The block takes one item at a time: a new item is accepted only once the current one is finished.
// Reset is synchronous and clears all timers, the allocation count and the result valid flag.
// ---------------------------------------------------------------------------
// periodic_timer_pool: pool of periodic countdown timers
// Create, start, stop and query requests, plus ticks that emit fired items.
// ---------------------------------------------------------------------------
module periodic_timer_pool (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  ptp_pkg::req_item_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output ptp_pkg::rsp_item_type rsp_data
);

   ptp_pkg::ctrl_cmd_type  cmd;
   ptp_pkg::dp_status_type status;

   ptp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   ptp_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // The block takes no new item until the current one is finished.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("item accepted while the previous one is in work");

   a_one_command: assert property (@(posedge clock) disable iff (reset)
      $onehot0(cmd))
      else $error("controller issued more than one command");

   a_ack_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.result_kind == ptp_pkg::KIND_ACK) |-> rsp_data.last)
      else $error("acknowledgement without last");

   a_fired_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.result_kind == ptp_pkg::KIND_FIRED) |->
         (rsp_data.status == ptp_pkg::ST_OK && !rsp_data.active))
      else $error("fired item with bad status or active");

endmodule

@@ sv/ptp_ctrl.sv @@
// ---------------------------------------------------------------------------
// ptp_ctrl: sequencer of the periodic timer pool
// Accepts one item at a time, dispatches requests and steps the tick walk.
// ---------------------------------------------------------------------------
module ptp_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  ptp_pkg::dp_status_type status,
   output ptp_pkg::ctrl_cmd_type  cmd
);

   localparam logic [1:0] S_IDLE     = 2'd0;
   localparam logic [1:0] S_DISPATCH = 2'd1;
   localparam logic [1:0] S_WALK     = 2'd2;
   localparam logic [1:0] S_FLUSH    = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            if (status.is_tick) begin
               cmd.walk_start = 1'b1;
               state_in       = S_WALK;
            end else if (status.out_free) begin
               cmd.exec_req = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_WALK: begin
            // A second firing slot has to wait until the held one can be sent.
            if (!status.walk_blocked) begin
               cmd.walk_step = 1'b1;
               if (status.walk_last) begin
                  state_in = S_FLUSH;
               end
            end
         end
         S_FLUSH: begin
            if (!status.pending) begin
               state_in = S_IDLE;
            end else if (status.out_free) begin
               cmd.flush = 1'b1;
               state_in  = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ sv/ptp_dp.sv @@
// ---------------------------------------------------------------------------
// ptp_dp: datapath of the periodic timer pool
// Timer storage, request register, tick walk index, held fired slot and
// the result register.
// ---------------------------------------------------------------------------
module ptp_dp (
   input  logic                   clock,
   input  logic                   reset,
   input  ptp_pkg::req_item_type  req_data,
   input  ptp_pkg::ctrl_cmd_type  cmd,
   output ptp_pkg::dp_status_type status,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output ptp_pkg::rsp_item_type  rsp_data
);

   localparam logic [ptp_pkg::SLOT_W-1:0] LAST_SLOT = ptp_pkg::SLOT_W'(ptp_pkg::TIMERS - 1);

   ptp_pkg::req_item_type req_ff;
   logic [ptp_pkg::CNT_W-1:0]  alloc_ff;
   logic [31:0]                period_ff    [ptp_pkg::TIMERS];
   logic [31:0]                remaining_ff [ptp_pkg::TIMERS];
   logic [ptp_pkg::TIMERS-1:0] handler_ff;
   logic [ptp_pkg::SLOT_W-1:0] idx_ff;
   logic                       pending_ff;
   logic [ptp_pkg::SLOT_W-1:0] pend_id_ff;
   logic                       rsp_valid_ff;
   ptp_pkg::rsp_item_type      rsp_data_ff;

   logic                       is_tick;
   logic [ptp_pkg::SLOT_W-1:0] req_slot;
   logic [ptp_pkg::SLOT_W-1:0] alloc_slot;
   logic [ptp_pkg::SLOT_W-1:0] rd_addr;
   logic [31:0]                per_rd;
   logic [31:0]                rem_rd;
   logic                       hnd_rd;
   logic                       idx_alloc;
   logic                       running;
   logic [31:0]                rem_dec;
   logic                       expire;
   logic                       hit;
   logic                       out_free;
   logic                       pool_full;
   logic                       refused;
   logic [31:0]                product;
   ptp_pkg::rsp_item_type      ack;

   assign is_tick    = (req_ff.req_type == ptp_pkg::REQ_TICK);
   assign req_slot   = ptp_pkg::SLOT_W'(req_ff.timer_id);
   assign alloc_slot = ptp_pkg::SLOT_W'(alloc_ff);
   assign rd_addr    = is_tick ? idx_ff : req_slot;
   assign per_rd     = period_ff[rd_addr];
   assign rem_rd     = remaining_ff[rd_addr];
   assign hnd_rd     = handler_ff[rd_addr];

   // The tick walk steps one slot per cycle while not blocked, from the top slot down.
   assign idx_alloc = (32'(idx_ff) < 32'(alloc_ff));
   assign running   = idx_alloc && (per_rd != 32'd0);
   assign rem_dec   = rem_rd - 32'd1;
   assign expire    = running && (rem_dec == 32'd0);
   assign hit       = expire && hnd_rd;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   assign pool_full = (32'(alloc_ff) >= ptp_pkg::TIMERS);
   assign refused   = (req_ff.req_type > ptp_pkg::REQ_QUERY) ||
                      (32'(req_ff.timer_id) >= 32'(alloc_ff)) ||
                      (32'(req_ff.timer_id) >= ptp_pkg::TIMERS);
   assign product   = 32'(req_ff.multiplier) * 32'(req_ff.count);

   always_comb begin
      ack              = '0;
      ack.result_kind  = ptp_pkg::KIND_ACK;
      ack.last         = 1'b1;
      ack.timer_id_res = req_ff.timer_id;
      ack.status       = ptp_pkg::ST_OK;
      if (req_ff.req_type == ptp_pkg::REQ_CREATE) begin
         if (pool_full) begin
            ack.status       = ptp_pkg::ST_FULL;
            ack.timer_id_res = 3'd0;
         end else begin
            ack.timer_id_res = 3'(alloc_ff);
         end
      end else if (refused) begin
         ack.status = ptp_pkg::ST_REFUSED;
      end else if (req_ff.req_type == ptp_pkg::REQ_QUERY) begin
         ack.active = (per_rd != 32'd0);
      end
   end

   assign status.is_tick      = is_tick;
   assign status.walk_last    = (idx_ff == '0);
   assign status.walk_blocked = hit && pending_ff && !out_free;
   assign status.pending      = pending_ff;
   assign status.out_free     = out_free;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         alloc_ff   <= '0;
         handler_ff <= '0;
         for (int i = 0; i < ptp_pkg::TIMERS; i++) begin
            period_ff[i]    <= '0;
            remaining_ff[i] <= '0;
         end
      end else if (cmd.exec_req) begin
         if (req_ff.req_type == ptp_pkg::REQ_CREATE) begin
            if (!pool_full) begin
               handler_ff[alloc_slot]   <= req_ff.has_handler;
               period_ff[alloc_slot]    <= '0;
               remaining_ff[alloc_slot] <= '0;
               alloc_ff                 <= alloc_ff + 1'b1;
            end
         end else if (!refused) begin
            if (req_ff.req_type == ptp_pkg::REQ_START) begin
               period_ff[req_slot]    <= product;
               remaining_ff[req_slot] <= product;
            end else if (req_ff.req_type == ptp_pkg::REQ_STOP) begin
               period_ff[req_slot]    <= '0;
               remaining_ff[req_slot] <= '0;
            end
         end
      end else if (cmd.walk_step && running) begin
         remaining_ff[idx_ff] <= expire ? per_rd : rem_dec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff     <= '0;
         pending_ff <= 1'b0;
      end else if (cmd.walk_start) begin
         idx_ff     <= LAST_SLOT;
         pending_ff <= 1'b0;
      end else if (cmd.walk_step) begin
         idx_ff <= idx_ff - 1'b1;
         if (hit) begin
            pending_ff <= 1'b1;
         end
      end else if (cmd.flush) begin
         pending_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.walk_step && hit) begin
         pend_id_ff <= idx_ff;
      end
   end

   // The held fired slot goes out once the next one is found, or at the end
   // of the walk, where it is the last result of the tick.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.exec_req) begin
         rsp_valid_ff <= 1'b1;
         rsp_data_ff  <= ack;
      end else if ((cmd.walk_step && hit && pending_ff) || cmd.flush) begin
         rsp_valid_ff              <= 1'b1;
         rsp_data_ff.result_kind   <= ptp_pkg::KIND_FIRED;
         rsp_data_ff.timer_id_res  <= 3'(pend_id_ff);
         rsp_data_ff.status        <= ptp_pkg::ST_OK;
         rsp_data_ff.active        <= 1'b0;
         rsp_data_ff.last          <= cmd.flush;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench: self-checking bench for the periodic timer pool
// Drives create, start, stop, query, tick and unknown requests in bursts
// while the result side stalls in changing patterns. A scoreboard keeps its
// own copy of the timer slots and checks each result item in order.
// ---------------------------------------------------------------------------
module testbench;

   localparam int IDLE_LIMIT   = 2000;
   localparam int RANDOM_ITEMS = 104;
   localparam int DRAIN_CYCLES = 30;
   localparam int PRINT_LIMIT  = 30;

   // Request codes above query are not defined and must be refused.
   localparam logic [2:0] REQ_UNKNOWN_LO = 3'd5;
   localparam logic [2:0] REQ_UNKNOWN_HI = 3'd7;

   typedef enum int {STALL_NONE, STALL_PERIODIC, STALL_RANDOM} stall_mode_type;

   class timer_pool_scoreboard;
      int                    slots_taken;
      logic [31:0]           reload_value [ptp_pkg::TIMERS];
      logic [31:0]           countdown [ptp_pkg::TIMERS];
      logic                  fires_event [ptp_pkg::TIMERS];
      ptp_pkg::rsp_item_type pending_results [$];
      int                    errors;
      int                    ticks_seen;
      int                    acks_seen;
      int                    fired_seen;

      function new();
         slots_taken = 0;
         errors = 0;
         ticks_seen = 0;
         acks_seen = 0;
         fired_seen = 0;
         foreach (reload_value[s]) begin
            reload_value[s] = '0;
            countdown[s] = '0;
            fires_event[s] = 1'b0;
         end
      endfunction

      function ptp_pkg::rsp_item_type make_result(logic kind, logic [2:0] slot,
                                                  logic [1:0] st, logic act, logic lst);
         ptp_pkg::rsp_item_type r;
         r.result_kind = kind;
         r.timer_id_res = slot;
         r.status = st;
         r.active = act;
         r.last = lst;
         return r;
      endfunction

      function void note_request(ptp_pkg::req_item_type item);
         int unsigned           first;
         ptp_pkg::rsp_item_type r;
         first = pending_results.size();
         case (item.req_type)
            ptp_pkg::REQ_TICK: begin
               ticks_seen++;
               for (int s = slots_taken - 1; s >= 0; s--) begin
                  if (reload_value[s] != 0) begin
                     countdown[s] = countdown[s] - 1;
                     if (countdown[s] == 0) begin
                        countdown[s] = reload_value[s];
                        if (fires_event[s])
                           pending_results.push_back(
                              make_result(ptp_pkg::KIND_FIRED, 3'(s), ptp_pkg::ST_OK,
                                          1'b0, 1'b0));
                     end
                  end
               end
               // The lowest firing slot with a handler closes the tick.
               if (pending_results.size() > first) begin
                  r = pending_results.pop_back();
                  r.last = 1'b1;
                  pending_results.push_back(r);
               end
            end
            ptp_pkg::REQ_CREATE: begin
               if (slots_taken >= ptp_pkg::TIMERS) begin
                  pending_results.push_back(
                     make_result(ptp_pkg::KIND_ACK, 3'd0, ptp_pkg::ST_FULL, 1'b0, 1'b1));
               end else begin
                  fires_event[slots_taken] = item.has_handler;
                  reload_value[slots_taken] = '0;
                  countdown[slots_taken] = '0;
                  pending_results.push_back(
                     make_result(ptp_pkg::KIND_ACK, 3'(slots_taken), ptp_pkg::ST_OK,
                                 1'b0, 1'b1));
                  slots_taken++;
               end
            end
            default: begin
               if (item.req_type > ptp_pkg::REQ_QUERY || item.timer_id >= slots_taken) begin
                  pending_results.push_back(
                     make_result(ptp_pkg::KIND_ACK, item.timer_id, ptp_pkg::ST_REFUSED,
                                 1'b0, 1'b1));
               end else if (item.req_type == ptp_pkg::REQ_START) begin
                  reload_value[item.timer_id] = {16'd0, item.multiplier} * {16'd0, item.count};
                  countdown[item.timer_id] = reload_value[item.timer_id];
                  pending_results.push_back(
                     make_result(ptp_pkg::KIND_ACK, item.timer_id, ptp_pkg::ST_OK, 1'b0, 1'b1));
               end else if (item.req_type == ptp_pkg::REQ_STOP) begin
                  reload_value[item.timer_id] = '0;
                  countdown[item.timer_id] = '0;
                  pending_results.push_back(
                     make_result(ptp_pkg::KIND_ACK, item.timer_id, ptp_pkg::ST_OK, 1'b0, 1'b1));
               end else begin
                  pending_results.push_back(
                     make_result(ptp_pkg::KIND_ACK, item.timer_id, ptp_pkg::ST_OK,
                                 reload_value[item.timer_id] != 0, 1'b1));
               end
            end
         endcase
      endfunction

      task report(string msg);
         errors++;
         if (errors <= PRINT_LIMIT)
            $display("mismatch: %s", msg);
      endtask

      task check_result(ptp_pkg::rsp_item_type got);
         ptp_pkg::rsp_item_type want;
         string                 bad;
         bad = "";
         if (got.result_kind === ptp_pkg::KIND_FIRED)
            fired_seen++;
         else
            acks_seen++;
         if (pending_results.size() == 0) begin
            report($sformatf("unexpected result kind=%0d slot=%0d status=%0d active=%0d last=%0d",
                             got.result_kind, got.timer_id_res, got.status, got.active,
                             got.last));
            return;
         end
         want = pending_results.pop_front();
         if (got.result_kind !== want.result_kind) bad = {bad, " result_kind"};
         if (got.timer_id_res !== want.timer_id_res) bad = {bad, " timer_id_res"};
         if (got.status !== want.status) bad = {bad, " status"};
         if (got.active !== want.active) bad = {bad, " active"};
         if (got.last !== want.last) bad = {bad, " last"};
         if (bad != "")
            report($sformatf("wrong%s: got %0d/%0d/%0d/%0d/%0d, wanted %0d/%0d/%0d/%0d/%0d",
                             bad, got.result_kind, got.timer_id_res, got.status, got.active,
                             got.last, want.result_kind, want.timer_id_res, want.status,
                             want.active, want.last));
      endtask
   endclass

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   ptp_pkg::req_item_type req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   ptp_pkg::rsp_item_type rsp_data;

   timer_pool_scoreboard  board;
   ptp_pkg::req_item_type stimulus_q [$];
   int                    idle_cycles = 0;
   stall_mode_type        stall_mode = STALL_NONE;
   int                    stall_left = 0;
   int                    stall_run = 0;

   periodic_timer_pool dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic ptp_pkg::req_item_type make_request(logic [2:0] kind, logic [2:0] slot,
                                                          logic handler, logic [15:0] mul,
                                                          logic [15:0] cnt);
      ptp_pkg::req_item_type item;
      item.req_type = kind;
      item.timer_id = slot;
      item.has_handler = handler;
      item.multiplier = mul;
      item.count = cnt;
      return item;
   endfunction

   task automatic send_item(input ptp_pkg::req_item_type item);
      req_valid <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Handshakes are sampled with the values present just before the edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) board.note_request(req_data);
         if (rsp_valid && !rsp_stall) board.check_result(rsp_data);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
                     idle_cycles, board.pending_results.size());
            $display("tb: failure");
            $finish;
         end
      end
   end

   // The result side switches between no stall, a periodic stall when its mode counter is a
   // multiple of three, and random stalls whose runs in a row are capped by a run counter.
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode = stall_mode_type'($urandom_range(0, 2));
         stall_left = $urandom_range(20, 80);
      end
      stall_left--;
      case (stall_mode)
         STALL_NONE: begin
            rsp_stall <= 1'b0;
         end
         STALL_PERIODIC: begin
            rsp_stall <= (stall_left % 3 == 0);
         end
         default: begin
            if (stall_run >= 6 || $urandom_range(0, 1) == 0) begin
               rsp_stall <= 1'b0;
               stall_run = 0;
            end else begin
               rsp_stall <= 1'b1;
               stall_run++;
            end
         end
      endcase
   end

   initial begin
      ptp_pkg::req_item_type item;
      int                    pick;
      int                    shape;
      int                    burst;
      int                    gap;
      int                    total;

      board = new();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Everything before any create is refused, and a tick gives nothing.
      stimulus_q.push_back(make_request(ptp_pkg::REQ_TICK, 3'd0, 1'b0, 16'd0, 16'd0));
      stimulus_q.push_back(make_request(ptp_pkg::REQ_QUERY, 3'd0, 1'b0, 16'd0, 16'd0));
      stimulus_q.push_back(make_request(ptp_pkg::REQ_START, 3'd7, 1'b1, 16'hFFFF, 16'hFFFF));
      stimulus_q.push_back(make_request(ptp_pkg::REQ_STOP, 3'd3, 1'b0, 16'd0, 16'd0));
      stimulus_q.push_back(make_request(REQ_UNKNOWN_LO, 3'd2, 1'b0, 16'd0, 16'd0));
      stimulus_q.push_back(make_request(REQ_UNKNOWN_HI, 3'd7, 1'b1, 16'hFFFF, 16'hFFFF));
      stimulus_q.push_back(make_request(ptp_pkg::REQ_CREATE, 3'd5, 1'b1, 16'd0, 16'd0));
      stimulus_q.push_back(make_request(ptp_pkg::REQ_QUERY, 3'd1, 1'b0, 16'd0, 16'd0));
      stimulus_q.push_back(make_request(ptp_pkg::REQ_START, 3'd0, 1'b0, 16'd1, 16'd1));
      stimulus_q.push_back(make_request(ptp_pkg::REQ_CREATE, 3'd0, 1'b0, 16'd0, 16'd0));
      stimulus_q.push_back(make_request(ptp_pkg::REQ_START, 3'd1, 1'b0, 16'hFFFF, 16'hFFFF));
      stimulus_q.push_back(make_request(ptp_pkg::REQ_QUERY, 3'd1, 1'b0, 16'd0, 16'd0));
      stimulus_q.push_back(make_request(ptp_pkg::REQ_TICK, 3'd0, 1'b0, 16'd0, 16'd0));
      // Fill the pool; of slots 2 to 7 the odd ones get a handler, then one create too many.
      for (int s = 2; s < ptp_pkg::TIMERS; s++)
         stimulus_q.push_back(make_request(ptp_pkg::REQ_CREATE, 3'd0, 1'(s % 2),
                                           16'd0, 16'd0));
      stimulus_q.push_back(make_request(ptp_pkg::REQ_CREATE, 3'd0, 1'b1, 16'd0, 16'd0));
      stimulus_q.push_back(make_request(ptp_pkg::REQ_START, 3'd7, 1'b0, 16'd1, 16'd1));
      stimulus_q.push_back(make_request(ptp_pkg::REQ_START, 3'd5, 1'b0, 16'd0, 16'd9));
      stimulus_q.push_back(make_request(ptp_pkg::REQ_QUERY, 3'd5, 1'b0, 16'd0, 16'd0));
      stimulus_q.push_back(make_request(ptp_pkg::REQ_TICK, 3'd0, 1'b0, 16'd0, 16'd0));
      stimulus_q.push_back(make_request(ptp_pkg::REQ_STOP, 3'd0, 1'b0, 16'd0, 16'd0));
      stimulus_q.push_back(make_request(ptp_pkg::REQ_TICK, 3'd0, 1'b0, 16'd0, 16'd0));

      // Short periods dominate so that timers expire often.
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         pick = $urandom_range(0, 99);
         item = make_request(3'd0, 3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                             16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
         if (pick < 40) begin
            item.req_type = ptp_pkg::REQ_TICK;
         end else if (pick < 65) begin
            item.req_type = ptp_pkg::REQ_START;
            shape = $urandom_range(0, 9);
            if (shape == 0) begin
               item.multiplier = '0;
            end else if (shape == 1) begin
               item.count = '0;
            end else if (shape >= 4) begin
               item.multiplier = 16'($urandom_range(1, 3));
               item.count = 16'($urandom_range(1, 5));
            end
         end else if (pick < 75) begin
            item.req_type = ptp_pkg::REQ_STOP;
         end else if (pick < 90) begin
            item.req_type = ptp_pkg::REQ_QUERY;
         end else if (pick < 95) begin
            item.req_type = ptp_pkg::REQ_CREATE;
         end else begin
            item.req_type = 3'($urandom_range(REQ_UNKNOWN_LO, REQ_UNKNOWN_HI));
         end
         stimulus_q.push_back(item);
      end

      total = stimulus_q.size();
      while (stimulus_q.size() > 0) begin
         burst = $urandom_range(1, 8);
         while (burst > 0 && stimulus_q.size() > 0) begin
            send_item(stimulus_q.pop_front());
            burst--;
         end
         if (stimulus_q.size() == 0)
            gap = 1;
         else
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
         // Valid stays high across back-to-back bursts.
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end

      while (board.pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("summary: %0d items driven (%0d ticks), %0d acknowledgements and %0d fired",
               total, board.ticks_seen, board.acks_seen, board.fired_seen);
      $display("summary: %0d slots created, %0d mismatches", board.slots_taken, board.errors);
      if (board.errors == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

@@ periodic_timer_pool.f @@
sv/ptp_pkg.sv
sv/ptp_ctrl.sv
sv/ptp_dp.sv
sv/periodic_timer_pool.sv
bench/testbench.sv
